FILE: hw/rtl/ansi_sgr_pkg.sv
// Package for the ANSI SGR escape encoder: word types, command codes,
// character constants and the decimal helpers used by the front end.
// Depends on nothing.
`default_nettype none

package ansi_sgr_pkg;

	localparam int SLOTS       = 19;
	localparam int DIGITS      = 10;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [2:0] CMD_TRUE_FG = 3'd0;
	localparam logic [2:0] CMD_TRUE_BG = 3'd1;
	localparam logic [2:0] CMD_PAL_FG  = 3'd2;
	localparam logic [2:0] CMD_PAL_BG  = 3'd3;
	localparam logic [2:0] CMD_RESET   = 3'd4;
	localparam logic [2:0] CMD_REPEAT  = 3'd5;

	localparam logic [7:0] CH_ESC   = 8'h1b;
	localparam logic [7:0] CH_LBR   = 8'h5b;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_THREE = 8'h33;
	localparam logic [7:0] CH_FOUR  = 8'h34;
	localparam logic [7:0] CH_FIVE  = 8'h35;
	localparam logic [7:0] CH_EIGHT = 8'h38;
	localparam logic [7:0] CH_M     = 8'h6d;
	localparam logic [7:0] CH_B     = 8'h62;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  palette_index;
		logic [31:0] repeat_count;
	} cmd_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
	} byte_word_t;

	typedef logic [SLOTS-1:0][7:0] slot_bytes_t;
	typedef logic [SLOTS-1:0]      slot_mask_t;

	// fixed slot layout; mask marks the slots that are sent
	typedef struct packed {
		slot_bytes_t bytes;
		slot_mask_t  mask;
	} seq_t;

	typedef struct packed {
		logic push;
		seq_t entry;
	} q_wr_t;

	// 8-bit binary to three BCD digits (shift-and-add-3)
	function automatic logic [11:0] bcd8(input logic [7:0] v);
		logic [19:0] s;
		s = {12'd0, v};
		for (int i = 0; i < 8; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (s[8+4*j +: 4] >= 4'd5)
					s[8+4*j +: 4] = s[8+4*j +: 4] + 4'd3;
			end
			s = {s[18:0], 1'b0};
		end
		return s[19:8];
	endfunction

	function automatic logic [35:0] pow10(input logic [3:0] k);
		logic [35:0] p;
		case (k)
			4'd0:    p = 36'd1;
			4'd1:    p = 36'd10;
			4'd2:    p = 36'd100;
			4'd3:    p = 36'd1000;
			4'd4:    p = 36'd10000;
			4'd5:    p = 36'd100000;
			4'd6:    p = 36'd1000000;
			4'd7:    p = 36'd10000000;
			4'd8:    p = 36'd100000000;
			4'd9:    p = 36'd1000000000;
			default: p = 36'd0;
		endcase
		return p;
	endfunction

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		return CH_ZERO + {4'd0, d};
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ansi_sgr_chan_if.sv
// Valid/ready channel carrying one word of a given payload type.
// Used for the command input and the byte output of the SGR encoder.
`default_nettype none

interface ansi_sgr_chan_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ansi_sgr_front.sv
// Front end: accepts command words, lays each out as a slot sequence and
// converts repeat counts to decimal, one digit per cycle. Uses ansi_sgr_pkg.
`default_nettype none

module ansi_sgr_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	ansi_sgr_chan_if.sink              cmd_ch,
	input  wire logic                  full,
	output ansi_sgr_pkg::q_wr_t        q_wr
);

	localparam int DIGITS = ansi_sgr_pkg::DIGITS;

	logic                     busy_q;
	logic                     done_q;
	logic [3:0]               k_q;
	logic [31:0]              rem_q;
	logic [DIGITS-1:0][3:0]   dig_q;

	logic                     acc;
	logic [3:0]               digit;
	logic [35:0]              sub;
	logic [35:0]              mult;
	ansi_sgr_pkg::cmd_word_t  w;
	ansi_sgr_pkg::seq_t       e;
	logic [11:0]              bcd_a;
	logic [11:0]              bcd_b;
	logic [11:0]              bcd_c;
	logic                     seen;

	assign w            = cmd_ch.data;
	assign cmd_ch.ready = !busy_q && !done_q && !full;
	assign acc          = cmd_ch.valid && cmd_ch.ready;

	// largest digit d with d * 10^k <= remainder
	always_comb begin
		digit = 4'd0;
		sub   = 36'd0;
		mult  = 36'd0;
		for (int d = 1; d < 10; d++) begin
			mult = 36'(ansi_sgr_pkg::pow10(k_q) * 36'(d));
			if ({4'd0, rem_q} >= mult) begin
				digit = 4'(d);
				sub   = mult;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			if (acc && w.cmd == ansi_sgr_pkg::CMD_REPEAT) begin
				busy_q <= 1'b1;
				k_q    <= 4'(DIGITS - 1);
			end else if (busy_q) begin
				k_q <= k_q - 4'd1;
				if (k_q == 4'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (done_q && !full) begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rem_q <= w.repeat_count;
		end else if (busy_q) begin
			rem_q        <= rem_q - sub[31:0];
			dig_q[k_q]   <= digit;
		end
	end

	always_comb begin
		e     = '0;
		bcd_a = ansi_sgr_pkg::bcd8(w.red);
		bcd_b = ansi_sgr_pkg::bcd8(w.green);
		bcd_c = ansi_sgr_pkg::bcd8(w.blue);
		seen  = 1'b0;
		e.bytes[0] = ansi_sgr_pkg::CH_ESC;
		e.bytes[1] = ansi_sgr_pkg::CH_LBR;
		e.mask[1:0] = 2'b11;
		if (done_q) begin
			for (int j = 0; j < DIGITS; j++) begin
				seen = seen || (dig_q[DIGITS-1-j] != 4'd0) || (j == DIGITS - 1);
				e.bytes[2+j] = ansi_sgr_pkg::digit_char(dig_q[DIGITS-1-j]);
				e.mask[2+j]  = seen;
			end
			e.bytes[DIGITS+2] = ansi_sgr_pkg::CH_B;
			e.mask[DIGITS+2]  = 1'b1;
		end else if (w.cmd == ansi_sgr_pkg::CMD_RESET) begin
			e.bytes[2]  = ansi_sgr_pkg::CH_ZERO;
			e.bytes[3]  = ansi_sgr_pkg::CH_M;
			e.mask[3:2] = 2'b11;
		end else begin
			if (w.cmd == ansi_sgr_pkg::CMD_TRUE_FG || w.cmd == ansi_sgr_pkg::CMD_PAL_FG)
				e.bytes[2] = ansi_sgr_pkg::CH_THREE;
			else
				e.bytes[2] = ansi_sgr_pkg::CH_FOUR;
			e.bytes[3] = ansi_sgr_pkg::CH_EIGHT;
			e.bytes[4] = ansi_sgr_pkg::CH_SEMI;
			e.bytes[6] = ansi_sgr_pkg::CH_SEMI;
			e.mask[6:2] = 5'b11111;
			if (w.cmd == ansi_sgr_pkg::CMD_TRUE_FG || w.cmd == ansi_sgr_pkg::CMD_TRUE_BG) begin
				e.bytes[5] = ansi_sgr_pkg::CH_TWO;
			end else begin
				e.bytes[5] = ansi_sgr_pkg::CH_FIVE;
				bcd_a      = ansi_sgr_pkg::bcd8(w.palette_index);
			end
			for (int j = 0; j < 3; j++) begin
				e.bytes[7+j]  = ansi_sgr_pkg::digit_char(bcd_a[8-4*j +: 4]);
				e.bytes[11+j] = ansi_sgr_pkg::digit_char(bcd_b[8-4*j +: 4]);
				e.bytes[15+j] = ansi_sgr_pkg::digit_char(bcd_c[8-4*j +: 4]);
			end
			e.mask[7]  = bcd_a[11:8] != 4'd0;
			e.mask[8]  = bcd_a[11:4] != 8'd0;
			e.mask[9]  = 1'b1;
			if (w.cmd == ansi_sgr_pkg::CMD_TRUE_FG || w.cmd == ansi_sgr_pkg::CMD_TRUE_BG) begin
				e.bytes[10] = ansi_sgr_pkg::CH_SEMI;
				e.bytes[14] = ansi_sgr_pkg::CH_SEMI;
				e.bytes[18] = ansi_sgr_pkg::CH_M;
				e.mask[10]  = 1'b1;
				e.mask[11]  = bcd_b[11:8] != 4'd0;
				e.mask[12]  = bcd_b[11:4] != 8'd0;
				e.mask[13]  = 1'b1;
				e.mask[14]  = 1'b1;
				e.mask[15]  = bcd_c[11:8] != 4'd0;
				e.mask[16]  = bcd_c[11:4] != 8'd0;
				e.mask[17]  = 1'b1;
				e.mask[18]  = 1'b1;
			end else begin
				e.bytes[10] = ansi_sgr_pkg::CH_M;
				e.mask[10]  = 1'b1;
			end
		end
	end

	// codes above repeat are taken and dropped
	assign q_wr.push  = (acc && w.cmd <= ansi_sgr_pkg::CMD_RESET) || (done_q && !full);
	assign q_wr.entry = e;

endmodule

`default_nettype wire

FILE: hw/rtl/ansi_sgr_queue.sv
// Short register queue of slot sequences between front and back end.
// Uses ansi_sgr_pkg.
`default_nettype none

module ansi_sgr_queue #(
	parameter int DEPTH = ansi_sgr_pkg::QUEUE_DEPTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  ansi_sgr_pkg::q_wr_t       q_wr,
	input  wire logic                 pop,
	output logic                      full,
	output logic                      empty,
	output ansi_sgr_pkg::seq_t        head
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ansi_sgr_pkg::seq_t mem_q [DEPTH];
	logic [IW-1:0]      wr_ptr_q;
	logic [IW-1:0]      rd_ptr_q;
	logic [CW-1:0]      cnt_q;
	logic               do_push;
	logic               do_pop;

	assign full    = cnt_q == CW'(DEPTH);
	assign empty   = cnt_q == '0;
	assign head    = mem_q[rd_ptr_q];
	assign do_push = q_wr.push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == IW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == IW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= q_wr.entry;
	end

endmodule

`default_nettype wire

FILE: hw/rtl/ansi_sgr_back.sv
// Back end: walks the sent slots of one sequence into an output register,
// one byte per cycle while the receiver is ready; marks the final byte. Uses ansi_sgr_pkg.
`default_nettype none

module ansi_sgr_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  ansi_sgr_pkg::seq_t       head,
	input  wire logic                empty,
	output logic                     pop,
	ansi_sgr_chan_if.source          byte_ch
);

	localparam int SLOTS = ansi_sgr_pkg::SLOTS;
	localparam int SW    = $clog2(SLOTS);

	ansi_sgr_pkg::slot_bytes_t bytes_q;
	ansi_sgr_pkg::slot_mask_t  rem_q;
	logic                      ov_q;
	logic [7:0]                ob_q;
	logic                      last_q;

	logic [SW-1:0]             idx;
	logic                      only_one;
	logic                      emit;
	ansi_sgr_pkg::slot_mask_t  rem_next;

	always_comb begin
		idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (rem_q[i])
				idx = SW'(i);
		end
	end

	assign rem_next = rem_q & (rem_q - 1'b1);
	assign only_one = rem_next == '0;
	assign emit     = (rem_q != '0) && (!ov_q || byte_ch.ready);
	assign pop      = !empty && ((rem_q == '0) || (emit && only_one));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			if (pop)
				rem_q <= head.mask;
			else if (emit)
				rem_q <= rem_next;
			if (emit)
				ov_q <= 1'b1;
			else if (byte_ch.ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			bytes_q <= head.bytes;
		if (emit) begin
			ob_q   <= bytes_q[idx];
			last_q <= only_one;
		end
	end

	assign byte_ch.valid          = ov_q;
	assign byte_ch.data.out_byte  = ob_q;
	assign byte_ch.data.last_byte = last_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ansi_sgr_escape_encoder_unit.sv
// ANSI SGR escape encoder, top level: front end, slot queue and byte
// serialiser. Uses ansi_sgr_pkg, ansi_sgr_chan_if and the three submodules.
//
// cmd_ch takes one colour command word (truecolour fg/bg, palette fg/bg,
// reset, repeat); byte_ch gives the escape sequence one byte per word, with
// last_byte set on the final byte. Codes 6 and 7 are taken and give nothing.
// A repeat command first has its count converted to decimal, ten digits,
// one digit a cycle, and is then handed to the queue as a sequence.
// The serialiser gives one byte per cycle on byte_ch while the receiver is
// ready; a command has 4 to 19 bytes. A repeat command holds cmd_ch.ready
// low until its digits are converted and its sequence is in the queue.
// The queue holds QUEUE_DEPTH laid-out sequences, so commands keep being
// taken while the serialiser is busy or the receiver stalls; a stall holds
// the output byte and, once the queue fills, drops cmd_ch.ready.
// Reset empties the queue and the output register; no state survives
// between commands.
`default_nettype none

module ansi_sgr_escape_encoder_unit #(
	parameter int QUEUE_DEPTH = ansi_sgr_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	ansi_sgr_chan_if.sink    cmd_ch,
	ansi_sgr_chan_if.source  byte_ch
);

	ansi_sgr_pkg::q_wr_t q_wr;
	ansi_sgr_pkg::seq_t  q_head;
	logic                q_full;
	logic                q_empty;
	logic                q_pop;

	ansi_sgr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_ch (cmd_ch),
		.full   (q_full),
		.q_wr   (q_wr)
	);

	ansi_sgr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.pop    (q_pop),
		.full   (q_full),
		.empty  (q_empty),
		.head   (q_head)
	);

	ansi_sgr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (q_head),
		.empty   (q_empty),
		.pop     (q_pop),
		.byte_ch (byte_ch)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr.push |-> !q_full)
		else $error("sequence pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("sequence popped from an empty queue");

	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		byte_ch.valid && byte_ch.ready && !byte_ch.data.last_byte |=> byte_ch.valid)
		else $error("gap inside an escape sequence");

endmodule

`default_nettype wire
